@@ hw/rtl/gww_pkg.sv @@
package gww_pkg;

  // Field widths are fixed by the text format: bytes and six-bit lengths.
  localparam int unsigned LenW      = 6;
  localparam int unsigned CharW     = 8;
  localparam int unsigned MAX_WIDTH = 60;
  localparam int unsigned QDepth    = 2;

  localparam logic [LenW-1:0] LINE_WIDTH_RESET = 6'd40;

  // Register indexes on the configuration port.
  localparam logic RegLineWidth = 1'b0;

  // Byte codes that the block treats specially.
  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharTab   = 8'h09;
  localparam logic [CharW-1:0] CharNl    = 8'h0A;
  localparam logic [CharW-1:0] CharNul   = 8'h00;

  // Separator placed in front of a flushed word.
  typedef enum logic [1:0] {
    SEP_NONE,
    SEP_SPACE,
    SEP_NL,
    SEP_PARA
  } sep_e;

  // Playback sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEP,
    BK_WORD,
    BK_NL,
    BK_ERR
  } back_state_e;

  // One command per input byte that yields output.
  typedef struct packed {
    logic            err;
    sep_e            sep;
    logic [LenW-1:0] wlen;
    logic            bank;
    logic            fin;
  } cmd_t;

  // Write into the word buffer.
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [LenW-1:0]  idx;
    logic [CharW-1:0] data;
  } wr_req_t;

  // Word buffer bank released by playback.
  typedef struct packed {
    logic valid;
    logic bank;
  } done_t;

  // First playback state of a freshly popped command.
  function automatic back_state_e first_state(cmd_t cmd);
    back_state_e st;
    if (cmd.err) begin
      st = BK_ERR;
    end else if (cmd.sep != SEP_NONE) begin
      st = BK_SEP;
    end else if (cmd.wlen != '0) begin
      st = BK_WORD;
    end else if (cmd.fin) begin
      st = BK_NL;
    end else begin
      st = BK_IDLE;
    end
    return st;
  endfunction

endpackage

@@ hw/rtl/gww_if.sv @@
// Input channel: one text byte per beat.
interface gww_in_if;
  logic                        valid;
  logic                        ready;
  logic [gww_pkg::CharW-1:0]   ch;
  logic                        end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

// Output channel: one wrapped byte or the error result per beat.
interface gww_out_if;
  logic                        valid;
  logic                        ready;
  logic [gww_pkg::CharW-1:0]   out_char;
  logic                        error;
  logic                        last_of_run;

  modport source (output valid, output out_char, output error, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_char, input error, input last_of_run,
                  output ready);
endinterface

@@ hw/rtl/gww_cmd_fifo.sv @@
module gww_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gww_pkg::cmd_t data_i,
  input  logic          pop_i,
  output gww_pkg::cmd_t data_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (gww_pkg::QDepth > 1) ? $clog2(gww_pkg::QDepth) : 1;
  localparam int unsigned CntW = $clog2(gww_pkg::QDepth + 1);

  gww_pkg::cmd_t       mem_q [gww_pkg::QDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(gww_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(gww_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(gww_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("command queue written while full");
`endif

endmodule

@@ hw/rtl/gww_front.sv @@
module gww_front #(
  parameter int unsigned MaxWidth = gww_pkg::MAX_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [gww_pkg::LenW-1:0]   line_width_i,
  gww_in_if.sink                     in_i,
  input  logic                       full_i,
  output logic                       push_o,
  output gww_pkg::cmd_t              cmd_o,
  output gww_pkg::wr_req_t           wr_o,
  input  gww_pkg::done_t             done_i
);

  localparam int unsigned LenW = gww_pkg::LenW;

  logic [LenW-1:0] wl_q, wl_d;
  logic [LenW-1:0] ll_q, ll_d;
  logic [1:0]      nl_q, nl_d;
  logic            any_q, any_d;
  logic            errs_q, errs_d;
  logic            bank_q, bank_d;
  logic [1:0]      busy_q, busy_d;

  logic            accept;
  logic            is_ws;
  logic            is_nl;
  logic            last;
  logic            active;
  logic            err_now;
  logic [LenW-1:0] eff_w;
  logic [LenW-1:0] flush_len;
  logic            do_flush;
  logic [LenW:0]   fit_sum;
  gww_pkg::sep_e   sep;
  logic [LenW-1:0] new_ll;
  logic            has_res;

  // Effective width: zero acts as one, wide settings clamp to the buffer.
  always_comb begin
    if (line_width_i == '0) begin
      eff_w = LenW'(1);
    end else if (line_width_i > LenW'(MaxWidth)) begin
      eff_w = LenW'(MaxWidth);
    end else begin
      eff_w = line_width_i;
    end
  end

  // Hold off while the queue is full or the bank to be filled is still replayed.
  assign in_i.ready = !full_i && !busy_q[bank_q];
  assign accept     = in_i.valid && in_i.ready;

  assign is_nl  = (in_i.ch == gww_pkg::CharNl);
  assign is_ws  = is_nl || (in_i.ch == gww_pkg::CharSpace) || (in_i.ch == gww_pkg::CharTab);
  assign last   = in_i.end_of_text;
  assign active = !errs_q;

  assign err_now = active && !is_ws && (wl_q >= eff_w);

  // Length of the word that this byte flushes, zero if none.
  always_comb begin
    if (!active || err_now) begin
      flush_len = '0;
    end else if (is_ws) begin
      flush_len = wl_q;
    end else if (last) begin
      flush_len = wl_q + 1'b1;
    end else begin
      flush_len = '0;
    end
  end
  assign do_flush = (flush_len != '0);

  // Separator choice for the flushed word.
  assign fit_sum = {1'b0, ll_q} + {1'b0, flush_len} + (LenW+1)'(1);
  always_comb begin
    if (!any_q) begin
      sep = gww_pkg::SEP_NONE;
    end else if (nl_q >= 2'd2) begin
      sep = gww_pkg::SEP_PARA;
    end else if (fit_sum > {1'b0, eff_w}) begin
      sep = gww_pkg::SEP_NL;
    end else begin
      sep = gww_pkg::SEP_SPACE;
    end
  end

  always_comb begin
    case (sep)
      gww_pkg::SEP_SPACE: new_ll = fit_sum[LenW-1:0];
      gww_pkg::SEP_NONE:  new_ll = ll_q + flush_len;
      default:            new_ll = flush_len;
    endcase
  end

  // Command for the playback side.
  always_comb begin
    cmd_o.err  = err_now;
    cmd_o.sep  = do_flush ? sep : gww_pkg::SEP_NONE;
    cmd_o.wlen = flush_len;
    cmd_o.bank = bank_q;
    cmd_o.fin  = active && last && !err_now && (any_q || do_flush);
  end
  assign has_res = cmd_o.err || do_flush || cmd_o.fin;
  assign push_o  = accept && has_res;

  // Word characters go straight into the current bank.
  always_comb begin
    wr_o.en   = accept && active && !is_ws && !err_now;
    wr_o.bank = bank_q;
    wr_o.idx  = wl_q;
    wr_o.data = in_i.ch;
  end

  // Text state update.
  always_comb begin
    wl_d   = wl_q;
    ll_d   = ll_q;
    nl_d   = nl_q;
    any_d  = any_q;
    errs_d = errs_q;
    bank_d = bank_q;
    if (accept) begin
      if (do_flush) begin
        bank_d = !bank_q;
      end
      if (last) begin
        wl_d   = '0;
        ll_d   = '0;
        nl_d   = '0;
        any_d  = 1'b0;
        errs_d = 1'b0;
      end else if (active) begin
        if (is_ws) begin
          if (do_flush) begin
            ll_d  = new_ll;
            any_d = 1'b1;
            wl_d  = '0;
            nl_d  = is_nl ? 2'd1 : 2'd0;
          end else if (is_nl && nl_q < 2'd2) begin
            nl_d = nl_q + 1'b1;
          end
        end else if (err_now) begin
          errs_d = 1'b1;
        end else begin
          wl_d = wl_q + 1'b1;
        end
      end
    end
  end

  // Bank ownership: set on a word command, released when playback is done.
  always_comb begin
    busy_d = busy_q;
    if (done_i.valid) begin
      busy_d[done_i.bank] = 1'b0;
    end
    if (push_o && do_flush) begin
      busy_d[bank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q   <= '0;
      ll_q   <= '0;
      nl_q   <= '0;
      any_q  <= 1'b0;
      errs_q <= 1'b0;
      bank_q <= 1'b0;
      busy_q <= '0;
    end else begin
      wl_q   <= wl_d;
      ll_q   <= ll_d;
      nl_q   <= nl_d;
      any_q  <= any_d;
      errs_q <= errs_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_write_idle_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> !busy_q[wr_o.bank])
    else $error("word buffer bank written during playback");
`endif

endmodule

@@ hw/rtl/gww_back.sv @@
module gww_back #(
  parameter int unsigned MaxWidth = gww_pkg::MAX_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  gww_pkg::cmd_t        head_i,
  output logic                 pop_o,
  input  gww_pkg::wr_req_t     wr_i,
  output gww_pkg::done_t       done_o,
  gww_out_if.source            res_o
);

  localparam int unsigned LenW  = gww_pkg::LenW;
  localparam int unsigned IW    = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned Depth = 2 ** (IW + 1);

  logic [gww_pkg::CharW-1:0] mem [Depth];
  logic [gww_pkg::CharW-1:0] rd_q;

  gww_pkg::back_state_e      st_q, st_d;
  gww_pkg::cmd_t             cmd_q, cmd_d;
  logic [IW-1:0]             idx_q, idx_d;
  logic                      para_q, para_d;

  logic                      out_valid_q, out_valid_d;
  logic [gww_pkg::CharW-1:0] out_char_q, out_char_d;
  logic                      out_err_q, out_err_d;
  logic                      out_last_q, out_last_d;

  logic                      load;
  logic                      idx_last;
  logic                      para_first;

  assign load       = !out_valid_q || res_o.ready;
  assign idx_last   = (LenW'(idx_q) == (cmd_q.wlen - 1'b1));
  assign para_first = (cmd_q.sep == gww_pkg::SEP_PARA) && !para_q;

  // Next state of the playback sequencer.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      gww_pkg::BK_IDLE: begin
        if (!empty_i) begin
          st_d = gww_pkg::first_state(head_i);
        end
      end
      gww_pkg::BK_SEP: begin
        if (load && !para_first) begin
          if (cmd_q.wlen != '0) begin
            st_d = gww_pkg::BK_WORD;
          end else if (cmd_q.fin) begin
            st_d = gww_pkg::BK_NL;
          end else begin
            st_d = gww_pkg::BK_IDLE;
          end
        end
      end
      gww_pkg::BK_WORD: begin
        if (load && idx_last) begin
          st_d = cmd_q.fin ? gww_pkg::BK_NL : gww_pkg::BK_IDLE;
        end
      end
      gww_pkg::BK_NL, gww_pkg::BK_ERR: begin
        if (load) begin
          st_d = gww_pkg::BK_IDLE;
        end
      end
      default: st_d = gww_pkg::BK_IDLE;
    endcase
  end

  // Sequencer outputs: command pop, buffer index and the result beat.
  always_comb begin
    pop_o       = (st_q == gww_pkg::BK_IDLE) && !empty_i;
    cmd_d       = pop_o ? head_i : cmd_q;
    idx_d       = idx_q;
    para_d      = para_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_char_d  = out_char_q;
    out_err_d   = out_err_q;
    out_last_d  = out_last_q;
    if (pop_o) begin
      idx_d  = '0;
      para_d = 1'b0;
    end
    unique case (st_q)
      gww_pkg::BK_SEP: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_err_d   = 1'b0;
          out_char_d  = (cmd_q.sep == gww_pkg::SEP_SPACE) ? gww_pkg::CharSpace
                                                           : gww_pkg::CharNl;
          out_last_d  = !para_first && (cmd_q.wlen == '0) && !cmd_q.fin;
          para_d      = 1'b1;
        end
      end
      gww_pkg::BK_WORD: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_err_d   = 1'b0;
          out_char_d  = rd_q;
          out_last_d  = idx_last && !cmd_q.fin;
          idx_d       = idx_q + 1'b1;
        end
      end
      gww_pkg::BK_NL: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_err_d   = 1'b0;
          out_char_d  = gww_pkg::CharNl;
          out_last_d  = 1'b1;
        end
      end
      gww_pkg::BK_ERR: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_err_d   = 1'b1;
          out_char_d  = gww_pkg::CharNul;
          out_last_d  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Release the word buffer bank once its word has been replayed.
  always_comb begin
    done_o.valid = (st_q != gww_pkg::BK_IDLE) && (st_d == gww_pkg::BK_IDLE) &&
                   (cmd_q.wlen != '0);
    done_o.bank  = cmd_q.bank;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.out_char    = out_char_q;
  assign res_o.error       = out_err_q;
  assign res_o.last_of_run = out_last_q;

  // Word buffer: two banks, read one entry ahead so data matches idx_q.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[{wr_i.bank, wr_i.idx[IW-1:0]}] <= wr_i.data;
    end
    rd_q <= mem[{cmd_d.bank, idx_d}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= gww_pkg::BK_IDLE;
      idx_q       <= '0;
      para_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      idx_q       <= idx_d;
      para_q      <= para_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    out_char_q <= out_char_d;
    out_err_q  <= out_err_d;
    out_last_q <= out_last_d;
  end

`ifndef NO_ASSERTIONS
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.error |-> res_o.last_of_run)
    else $error("error result not marked as last of run");

  a_idx_in_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == gww_pkg::BK_WORD |-> LenW'(idx_q) < cmd_q.wlen)
    else $error("word playback ran past the word length");

  a_pop_nonempty_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_i.err || head_i.wlen != '0 || head_i.fin)
    else $error("command without any result reached playback");
`endif

endmodule

@@ hw/rtl/greedy_word_wrap_unit.sv @@
// Greedy word wrap unit.
// Text enters on in_i one byte per beat (ch, end_of_text on the final byte).
// Wrapped text leaves on res_o one byte per beat; last_of_run marks the final
// result that an input byte causes, and an overlong word gives one result with
// error set, after which input is swallowed until end_of_text.
// line_width is written over the APB port at byte address 0; the user must
// write it only while the block is idle, which the block does not enforce.
// Reads return it. Reset sets it to 40 and empties all text state.
// Timing: a word character gives no output until the word ends. A byte that
// ends a word queues a command; playback pops it from the queue register and
// sends results via the output register, one per cycle while res_o takes them.
// The front takes more bytes while playback runs, limited by the two-entry
// command queue and the two word buffer banks: a new word cannot fill a bank
// still being replayed. When res_o stalls, the output register holds its beat
// and playback waits; input keeps flowing until the queue or banks fill.
module greedy_word_wrap_unit #(
  parameter int unsigned MaxWidth = gww_pkg::MAX_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gww_in_if.sink      in_i,
  gww_out_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [gww_pkg::LenW-1:0] line_width_q, line_width_d;

  gww_pkg::cmd_t    push_cmd;
  gww_pkg::cmd_t    head_cmd;
  gww_pkg::wr_req_t wr_req;
  gww_pkg::done_t   done;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = {{(32-gww_pkg::LenW){1'b0}}, line_width_q};

  always_comb begin
    line_width_d = line_width_q;
    if (psel && penable && pwrite && (paddr[2] == gww_pkg::RegLineWidth)) begin
      line_width_d = pwdata[gww_pkg::LenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= gww_pkg::LINE_WIDTH_RESET;
    end else begin
      line_width_q <= line_width_d;
    end
  end

  gww_front #(
    .MaxWidth (MaxWidth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_width_i (line_width_q),
    .in_i         (in_i),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .wr_o         (wr_req),
    .done_i       (done)
  );

  gww_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  gww_back #(
    .MaxWidth (MaxWidth)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head_cmd),
    .pop_o   (pop),
    .wr_i    (wr_req),
    .done_o  (done),
    .res_o   (res_o)
  );

endmodule
